### rtl/dtss_pkg.sv
package dtss_pkg;

  localparam int ROM_DEPTH_DEFAULT = 256;
  localparam int PATTERN_LEN = 216;
  localparam int TABLE_IDX_W = 8;
  localparam int BASE_W = 8;
  localparam int STEP_W = 6;
  localparam int SUM_W = 9;
  localparam int TRIG_W = 7;
  localparam int SEL_W = 3;

  localparam logic [STEP_W-1:0] LIMIT_RESET = 6'd15;
  localparam logic [STEP_W-1:0] LEN_MAX_WIDE = 6'd63;
  localparam logic [STEP_W-1:0] LEN_MAX_SHORT = 6'd15;
  localparam logic [STEP_W-1:0] LEN_SKIPPED = 6'd62;

  localparam logic [TRIG_W-1:0] PATTERN_TABLE [PATTERN_LEN] = '{
    7'd5, 7'd0, 7'd5, 7'd0, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd4, 7'd16, 7'd5, 7'd16, 7'd6, 7'd0, 7'd8, 7'd0,
    7'd5, 7'd0, 7'd4, 7'd0, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd5, 7'd1, 7'd4, 7'd0, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd8, 7'd0, 7'd10, 7'd12, 7'd0, 7'd8, 7'd8, 7'd0,
    7'd8, 7'd12, 7'd0, 7'd9, 7'd8, 7'd0, 7'd10, 7'd12,
    7'd0, 7'd9, 7'd10, 7'd0, 7'd8, 7'd12, 7'd0, 7'd8,
    7'd5, 7'd0, 7'd4, 7'd1, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd4, 7'd0, 7'd5, 7'd0, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd5, 7'd0, 7'd4, 7'd1, 7'd6, 7'd0, 7'd4, 7'd0,
    7'd4, 7'd0, 7'd5, 7'd0, 7'd6, 7'd0, 7'd4, 7'd2,
    7'd3, 7'd0, 7'd12, 7'd0, 7'd7, 7'd0, 7'd12, 7'd0,
    7'd5, 7'd0, 7'd12, 7'd0, 7'd7, 7'd0, 7'd12, 7'd2,
    7'd5, 7'd0, 7'd4, 7'd0, 7'd6, 7'd0, 7'd4, 7'd4,
    7'd4, 7'd4, 7'd4, 7'd1, 7'd4, 7'd2, 7'd4, 7'd0,
    7'd5, 7'd0, 7'd4, 7'd0, 7'd4, 7'd0, 7'd4, 7'd0,
    7'd20, 7'd0, 7'd4, 7'd0, 7'd5, 7'd0, 7'd4, 7'd0,
    7'd4, 7'd0, 7'd4, 7'd0, 7'd5, 7'd0, 7'd4, 7'd4,
    7'd20, 7'd0, 7'd4, 7'd0, 7'd6, 7'd0, 7'd6, 7'd0,
    7'd1, 7'd4, 7'd4, 7'd4, 7'd3, 7'd4, 7'd4, 7'd4,
    7'd5, 7'd4, 7'd8, 7'd4, 7'd7, 7'd4, 7'd0, 7'd20,
    7'd5, 7'd0, 7'd4, 7'd4, 7'd3, 7'd4, 7'd4, 7'd4,
    7'd1, 7'd4, 7'd4, 7'd4, 7'd15, 7'd0, 7'd12, 7'd4,
    7'd1, 7'd4, 7'd4, 7'd4, 7'd3, 7'd4, 7'd4, 7'd4,
    7'd5, 7'd4, 7'd0, 7'd4, 7'd7, 7'd20, 7'd4, 7'd4,
    7'd5, 7'd0, 7'd4, 7'd4, 7'd7, 7'd4, 7'd4, 7'd0,
    7'd5, 7'd4, 7'd4, 7'd8, 7'd7, 7'd12, 7'd6, 7'd4
  };

  function automatic logic [BASE_W-1:0] sel_base(input logic [SEL_W-1:0] sel);
    logic [BASE_W-1:0] base;
    unique case (sel)
      3'd0: base = 8'd0;
      3'd1: base = 8'd16;
      3'd2: base = 8'd32;
      3'd3: base = 8'd56;
      3'd4: base = 8'd88;
      3'd5: base = 8'd104;
      3'd6: base = 8'd120;
      default: base = 8'd152;
    endcase
    return base;
  endfunction

  function automatic logic [STEP_W-1:0] sel_max(input logic [SEL_W-1:0] sel);
    logic [STEP_W-1:0] maxlen;
    unique case (sel)
      3'd0, 3'd1, 3'd4, 3'd5: maxlen = 6'd15;
      3'd2: maxlen = 6'd23;
      3'd3, 3'd6: maxlen = 6'd31;
      default: maxlen = 6'd63;
    endcase
    return maxlen;
  endfunction

endpackage

### rtl/dtss_pattern_rom.sv
module dtss_pattern_rom #(
  parameter int ROM_DEPTH = dtss_pkg::ROM_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [dtss_pkg::SUM_W-1:0]   rd_addr,
  output logic [dtss_pkg::TRIG_W-1:0]  rd_data
);

  localparam int AW = $clog2(ROM_DEPTH + 1);
  localparam int XW = (AW > dtss_pkg::SUM_W) ? AW : dtss_pkg::SUM_W;

  logic [XW-1:0] addr_x;
  logic [dtss_pkg::TRIG_W-1:0] word;

  assign addr_x = XW'(rd_addr);

  always_comb begin
    word = '0;
    if (addr_x < XW'(dtss_pkg::PATTERN_LEN)) begin
      word = dtss_pkg::PATTERN_TABLE[addr_x[dtss_pkg::TABLE_IDX_W-1:0]];
    end
  end

  // Addresses at or beyond the depth read as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (addr_x < XW'(ROM_DEPTH)) begin
        rd_data <= word;
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

### rtl/drum_trigger_step_sequencer_core.sv
// An accepted clock edge passes through the registered ROM read and then the output register.
// Throughput: one item per cycle while the output is not stalled; an item with no clock change produces no result.
// Reset is synchronous and active high; it clears the pipeline, the last clock level,
// the step position and the pattern base, and sets the step limit to 15.
module drum_trigger_step_sequencer_core #(
  parameter int ROM_DEPTH = dtss_pkg::ROM_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          clock_level,
  input  logic [7:0]                    pot_pattern,
  input  logic [7:0]                    pot_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kick,
  output logic                          snare,
  output logic                          hihat,
  output logic                          open_hat,
  output logic                          clap,
  output logic                          extra_one,
  output logic                          extra_two,
  output logic [dtss_pkg::STEP_W-1:0]   step_index
);

  logic                          last_clock;
  logic [dtss_pkg::STEP_W-1:0]   step_position;
  logic [dtss_pkg::BASE_W-1:0]   pattern_base;
  logic [dtss_pkg::STEP_W-1:0]   step_limit;

  logic                          s1_valid;
  logic                          s1_rise;
  logic [dtss_pkg::STEP_W-1:0]   s1_step;

  logic                          in_fire;
  logic                          is_edge;
  logic                          is_rise;
  logic                          out_load;
  logic [dtss_pkg::STEP_W:0]     pos_inc;
  logic [dtss_pkg::STEP_W-1:0]   step_position_next;
  logic [dtss_pkg::SUM_W-1:0]    rom_addr;
  logic [dtss_pkg::TRIG_W-1:0]   rom_data;
  logic [dtss_pkg::TRIG_W-1:0]   trig;

  logic [dtss_pkg::SEL_W-1:0]    sel;
  logic [dtss_pkg::STEP_W-1:0]   max_len;
  logic [dtss_pkg::STEP_W-1:0]   raw_len;
  logic [dtss_pkg::STEP_W-1:0]   clamp_len;
  logic [dtss_pkg::STEP_W-1:0]   step_limit_next;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;
  assign is_edge  = clock_level != last_clock;
  assign is_rise  = is_edge && clock_level;

  always_comb begin
    pos_inc = {1'b0, step_position} + 7'd1;
    if (pos_inc > {1'b0, step_limit}) begin
      step_position_next = '0;
    end else begin
      step_position_next = pos_inc[dtss_pkg::STEP_W-1:0];
    end
  end

  assign rom_addr = dtss_pkg::SUM_W'(pattern_base) + dtss_pkg::SUM_W'(step_position_next);

  always_comb begin
    sel = pot_pattern[7:5];
    max_len = dtss_pkg::sel_max(sel);
    priority if (max_len == dtss_pkg::LEN_MAX_WIDE) begin
      raw_len = pot_length[7:2];
    end else if (max_len == dtss_pkg::LEN_MAX_SHORT) begin
      raw_len = {2'b00, pot_length[7:4]};
    end else begin
      raw_len = {1'b0, pot_length[7:3]};
    end
    clamp_len = (raw_len > max_len) ? max_len : raw_len;
    if (clamp_len == dtss_pkg::LEN_SKIPPED) begin
      step_limit_next = dtss_pkg::LEN_MAX_WIDE;
    end else begin
      step_limit_next = clamp_len;
    end
  end

  dtss_pattern_rom #(
    .ROM_DEPTH(ROM_DEPTH)
  ) u_rom (
    .clk    (clk),
    .rd_en  (in_fire && is_rise),
    .rd_addr(rom_addr),
    .rd_data(rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock    <= 1'b0;
      step_position <= '0;
      pattern_base  <= '0;
      step_limit    <= dtss_pkg::LIMIT_RESET;
    end else if (in_fire && is_edge) begin
      last_clock   <= clock_level;
      pattern_base <= dtss_pkg::sel_base(sel);
      step_limit   <= step_limit_next;
      if (is_rise) begin
        step_position <= step_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire && is_edge) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_edge) begin
      s1_rise <= is_rise;
      s1_step <= is_rise ? step_position_next : '0;
    end
  end

  assign trig = s1_rise ? rom_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kick       <= trig[0];
      snare      <= trig[1];
      hihat      <= trig[2];
      open_hat   <= trig[3];
      clap       <= trig[4];
      extra_one  <= trig[5];
      extra_two  <= trig[6];
      step_index <= s1_step;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_no_edge_holds_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_edge |=> $stable(step_position) && $stable(step_limit))
    else $error("Step state changed without a clock edge.");

  a_edge_enters_stage: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_edge |=> s1_valid)
    else $error("Clock edge transfer did not reach the pipeline.");

  a_limit_skips_62: assert property (@(posedge clk) disable iff (rst)
    step_limit != dtss_pkg::LEN_SKIPPED)
    else $error("Step limit holds a skipped length.");

  a_fall_zero_step: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_rise |-> s1_step == '0)
    else $error("Falling edge result carries a nonzero step.");

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;
  localparam int RANDOM_EDGES = 360;

  localparam bit [6:0] DRUM_PATTERNS [dtss_pkg::PATTERN_LEN] = '{
    5, 0, 5, 0, 6, 0, 4, 0,   4, 16, 5, 16, 6, 0, 8, 0,
    5, 0, 4, 0, 6, 0, 4, 0,   5, 1, 4, 0, 6, 0, 4, 0,
    8, 0, 10, 12, 0, 8, 8, 0, 8, 12, 0, 9, 8, 0, 10, 12,
    0, 9, 10, 0, 8, 12, 0, 8,
    5, 0, 4, 1, 6, 0, 4, 0,   4, 0, 5, 0, 6, 0, 4, 0,
    5, 0, 4, 1, 6, 0, 4, 0,   4, 0, 5, 0, 6, 0, 4, 2,
    3, 0, 12, 0, 7, 0, 12, 0, 5, 0, 12, 0, 7, 0, 12, 2,
    5, 0, 4, 0, 6, 0, 4, 4,   4, 4, 4, 1, 4, 2, 4, 0,
    5, 0, 4, 0, 4, 0, 4, 0,   20, 0, 4, 0, 5, 0, 4, 0,
    4, 0, 4, 0, 5, 0, 4, 4,   20, 0, 4, 0, 6, 0, 6, 0,
    1, 4, 4, 4, 3, 4, 4, 4,   5, 4, 8, 4, 7, 4, 0, 20,
    5, 0, 4, 4, 3, 4, 4, 4,   1, 4, 4, 4, 15, 0, 12, 4,
    1, 4, 4, 4, 3, 4, 4, 4,   5, 4, 0, 4, 7, 20, 4, 4,
    5, 0, 4, 4, 7, 4, 4, 0,   5, 4, 4, 8, 7, 12, 6, 4
  };

  localparam bit [dtss_pkg::BASE_W-1:0] BANK_BASE [8] = '{0, 16, 32, 56, 88, 104, 120, 152};
  localparam bit [dtss_pkg::STEP_W-1:0] BANK_MAX [8] = '{15, 15, 23, 31, 15, 15, 31, 63};

  typedef struct packed {
    logic [dtss_pkg::TRIG_W-1:0] trig;
    logic [dtss_pkg::STEP_W-1:0] step;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic clock_level = 1'b0;
  logic [7:0] pot_pattern = '0;
  logic [7:0] pot_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kick;
  logic snare;
  logic hihat;
  logic open_hat;
  logic clap;
  logic extra_one;
  logic extra_two;
  logic [dtss_pkg::STEP_W-1:0] step_index;

  step_result_t expected_steps[$];
  int mismatches = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic seq_level = 1'b0;
  logic [dtss_pkg::STEP_W-1:0] seq_pos = '0;
  logic [dtss_pkg::BASE_W-1:0] seq_base = '0;
  logic [dtss_pkg::STEP_W-1:0] seq_limit = dtss_pkg::LIMIT_RESET;

  drum_trigger_step_sequencer_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .clock_level(clock_level),
    .pot_pattern(pot_pattern),
    .pot_length(pot_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kick(kick),
    .snare(snare),
    .hihat(hihat),
    .open_hat(open_hat),
    .clap(clap),
    .extra_one(extra_one),
    .extra_two(extra_two),
    .step_index(step_index)
  );

  always #5 clk = ~clk;

  task automatic predict_edge(input logic lvl, input logic [7:0] pa, input logic [7:0] pb);
    step_result_t r;
    logic [dtss_pkg::STEP_W:0] nxt;
    logic [dtss_pkg::SUM_W-1:0] addr;
    logic [dtss_pkg::SEL_W-1:0] bank;
    logic [dtss_pkg::STEP_W-1:0] bank_max;
    logic [dtss_pkg::STEP_W-1:0] len;
    if (lvl == seq_level) return;
    seq_level = lvl;
    r = '0;
    if (lvl) begin
      nxt = {1'b0, seq_pos} + 7'd1;
      if (nxt > {1'b0, seq_limit}) nxt = '0;
      seq_pos = nxt[dtss_pkg::STEP_W-1:0];
      addr = {1'b0, seq_base} + {3'b000, seq_pos};
      r.trig = (addr < dtss_pkg::PATTERN_LEN) ?
               DRUM_PATTERNS[addr[dtss_pkg::TABLE_IDX_W-1:0]] : '0;
      r.step = seq_pos;
    end
    expected_steps.push_back(r);
    bank = pa[7:5];
    bank_max = BANK_MAX[bank];
    if (bank_max == dtss_pkg::LEN_MAX_WIDE) len = pb[7:2];
    else if (bank_max == dtss_pkg::LEN_MAX_SHORT) len = {2'b00, pb[7:4]};
    else len = {1'b0, pb[7:3]};
    if (len > bank_max) len = bank_max;
    if (len == dtss_pkg::LEN_SKIPPED) len = dtss_pkg::LEN_MAX_WIDE;
    seq_base = BANK_BASE[bank];
    seq_limit = len;
  endtask

  task automatic send_sample(input logic lvl, input logic [7:0] pa, input logic [7:0] pb);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    clock_level <= lvl;
    pot_pattern <= pa;
    pot_length <= pb;
    do @(posedge clk); while (!in_ready);
    predict_edge(lvl, pa, pb);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
  endtask

  task automatic test_reset_state();
    send_sample(1'b0, 8'hFF, 8'hFF);
    send_sample(1'b1, 8'h00, 8'h00);
    send_sample(1'b0, 8'h00, 8'hFF);
  endtask

  task automatic test_unchanged_level();
    repeat (3) send_sample(seq_level, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_pattern_selects();
    for (int s = 0; s < 8; s++) begin
      send_sample(~seq_level, {3'(s), 5'b00000}, 8'hFF);
      send_sample(~seq_level, {3'(s), 5'b11111}, 8'h00);
    end
  endtask

  task automatic test_wide_length_skip();
    send_sample(~seq_level, 8'hE0, 8'd248);
    send_sample(~seq_level, 8'hFF, 8'd251);
    send_sample(~seq_level, 8'hE0, 8'd252);
    send_sample(~seq_level, 8'hE0, 8'd255);
  endtask

  task automatic test_limit_shrink();
    repeat (4) send_sample(~seq_level, 8'hE0, 8'hFF);
    if (!seq_level) send_sample(1'b1, 8'h00, 8'h00);
    send_sample(~seq_level, 8'h00, 8'h00);
    send_sample(~seq_level, 8'h00, 8'h00);
  endtask

  // Pot settings are held for a run of clock edges, as a player would, so the step
  // counter reaches the longest patterns; some samples jitter the pots or repeat the level.
  task automatic test_random_traffic(input int edges);
    int sent;
    int run_len;
    logic [7:0] pa;
    logic [7:0] pb;
    sent = 0;
    while (sent < edges) begin
      pa = 8'($urandom);
      case ($urandom_range(0, 3))
        0: pb = 8'($urandom_range(248, 255));
        1: pb = 8'($urandom_range(0, 7));
        default: pb = 8'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0) run_len = $urandom_range(100, 150);
      else run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < edges; k++) begin
        case ($urandom_range(0, 9))
          0: send_sample(seq_level, 8'($urandom), 8'($urandom));
          1: begin
            send_sample(~seq_level, pa ^ 8'($urandom_range(0, 3)), pb ^ 8'($urandom_range(0, 7)));
            sent++;
          end
          default: begin
            send_sample(~seq_level, pa, pb);
            sent++;
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    step_result_t want;
    logic [dtss_pkg::TRIG_W-1:0] got_trig;
    if (!rst && out_valid && out_ready) begin
      got_trig = {extra_two, extra_one, clap, open_hat, hihat, snare, kick};
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result triggers=%b step=%0d", got_trig, step_index);
      end else begin
        want = expected_steps.pop_front();
        if (got_trig !== want.trig || step_index !== want.step) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: triggers expected %b actual %b, step expected %0d actual %0d",
                     want.trig, got_trig, want.step, step_index);
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 65;
    test_reset_state();
    test_unchanged_level();
    test_pattern_selects();
    test_wide_length_skip();
    test_limit_shrink();
    wait_until_drained();
    test_random_traffic(RANDOM_EDGES);
    wait_until_drained();
    send_idle_pct = 65;
    recv_idle_pct = 20;
    test_random_traffic(RANDOM_EDGES);
    wait_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_EDGES);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
